// ----- hdl/sacl_pkg.sv -----
// shared types and constants for the set-associative lru cache lookup
// no dependencies
`default_nettype none
package sacl_pkg;

  localparam int DEF_MAX_SETS  = 1024;
  localparam int DEF_MAX_WAYS  = 8;
  localparam int DEF_ADDR_BITS = 32;

  localparam int ADDR_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;
  localparam int RANK_W    = 3;
  localparam int NWAYS_W   = 3;   // ways in use minus one, up to 8 ways
  localparam int WAYOUT_W  = 3;
  localparam int CNT_W     = 32;
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS = 2'd0,
    CFG_SET_BITS    = 2'd1,
    CFG_WAYS_LOG    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0] offset_bits;
    logic [3:0] set_bits;
    logic [1:0] ways_log;
  } cfg_t;

  localparam logic [3:0] RST_OFFSET_BITS = 4'd4;
  localparam logic [3:0] RST_SET_BITS    = 4'd6;
  localparam logic [1:0] RST_WAYS_LOG    = 2'd0;

endpackage
`default_nettype wire

// ----- hdl/sacl_if.sv -----
// handshake interfaces for the address, result and configuration channels
// depends on sacl_pkg
`default_nettype none
interface sacl_in_if;
  logic                        valid;
  logic                        ready;
  logic [sacl_pkg::ADDR_W-1:0] address;
  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface sacl_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [sacl_pkg::WAYOUT_W-1:0] way_used;
  logic                          evicted;
  logic [sacl_pkg::CNT_W-1:0]    access_count;
  logic [sacl_pkg::CNT_W-1:0]    miss_count;
  modport source (output valid, output hit, output way_used, output evicted,
                  output access_count, output miss_count, input ready);
  modport sink   (input valid, input hit, input way_used, input evicted,
                  input access_count, input miss_count, output ready);
endinterface

interface sacl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sacl_pkg::CFG_IDX_W-1:0] index;
  logic [sacl_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/sacl_front.sv -----
// front end: splits an address into set index and tag, sizes the way count
// depends on sacl_pkg and sacl_if
`default_nettype none
module sacl_front #(
  parameter int MAX_SETS  = sacl_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS  = sacl_pkg::DEF_MAX_WAYS,
  parameter int ADDR_BITS = sacl_pkg::DEF_ADDR_BITS,
  parameter int IDX_W     = 1,
  parameter int TAG_W     = 32
) (
  input  sacl_pkg::cfg_t cfg_i,
  input  logic           en_i,
  sacl_in_if.sink        in_if,
  output logic           push_valid_o,
  input  logic           push_ready_i,
  output logic [IDX_W+TAG_W+sacl_pkg::NWAYS_W-1:0] push_data_o
);

  localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam logic [sacl_pkg::ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= sacl_pkg::ADDR_W) ?
      {sacl_pkg::ADDR_W{1'b1}} : sacl_pkg::ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  logic [sacl_pkg::ADDR_W-1:0]  addr_m, set_mask, off_sh, tag_sh;
  logic [3:0]                   ob;
  logic [4:0]                   sb;
  logic [5:0]                   tag_shift;
  logic [3:0]                   nways;
  logic [IDX_W-1:0]             set_idx;
  logic [TAG_W-1:0]             tag;
  logic [sacl_pkg::NWAYS_W-1:0] nways_m1;

  always_comb begin
    addr_m    = in_if.address & ADDR_MASK;
    ob        = (cfg_i.offset_bits > 4'd8) ? 4'd8 : cfg_i.offset_bits;
    sb        = (int'(cfg_i.set_bits) > SB_MAX) ? 5'(SB_MAX) : 5'(cfg_i.set_bits);
    set_mask  = (32'd1 << sb) - 32'd1;
    off_sh    = addr_m >> ob;
    set_idx   = IDX_W'(off_sh & set_mask);
    tag_shift = 6'(ob) + 6'(sb);
    tag_sh    = addr_m >> tag_shift;
    tag       = TAG_W'(tag_sh);
    nways     = 4'd1 << cfg_i.ways_log;
    if (int'(nways) > MAX_WAYS) begin
      nways = 4'(MAX_WAYS);
    end
    nways_m1  = sacl_pkg::NWAYS_W'(nways - 4'd1);
  end

  // no item enters while the store is being cleared
  assign in_if.ready  = en_i & push_ready_i;
  assign push_valid_o = en_i & in_if.valid;
  assign push_data_o  = {nways_m1, tag, set_idx};

endmodule
`default_nettype wire

// ----- hdl/sacl_fifo.sv -----
// small queue between front and back end
// depends on sacl_pkg
`default_nettype none
module sacl_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int DEPTH = sacl_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (int'(cnt_q) < DEPTH);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (int'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (int'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sacl_back.sv -----
// back end: set row read, tag compare, lru update and write back, counters
// depends on sacl_pkg and sacl_if
`default_nettype none
module sacl_back #(
  parameter int MAX_SETS = sacl_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS = sacl_pkg::DEF_MAX_WAYS,
  parameter int IDX_W    = 1,
  parameter int TAG_W    = 32,
  parameter int WAY_W    = 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  logic [IDX_W+TAG_W+sacl_pkg::NWAYS_W-1:0] pop_data_i,
  output logic        ready_o,
  sacl_out_if.source  out_if
);

  localparam int RW = sacl_pkg::RANK_W;
  localparam logic [IDX_W-1:0] LAST_SET = IDX_W'(MAX_SETS - 1);
  localparam logic [RW-1:0] RANK_MAX = {RW{1'b1}};

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EVAL  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [MAX_WAYS*TAG_W-1:0] tag_mem  [MAX_SETS];
  logic [MAX_WAYS-1:0]       vld_mem  [MAX_SETS];
  logic [MAX_WAYS*RW-1:0]    rank_mem [MAX_SETS];

  logic [MAX_WAYS*TAG_W-1:0] tag_rd_q, tag_wr;
  logic [MAX_WAYS-1:0]       vld_rd_q, vld_wr;
  logic [MAX_WAYS*RW-1:0]    rank_rd_q, rank_wr;

  logic [IDX_W-1:0]             clr_q, set_q, wr_idx;
  logic [TAG_W-1:0]             tag_q;
  logic [sacl_pkg::NWAYS_W-1:0] nwm1_q;

  logic rd_en, tag_we, meta_we, commit;

  logic [MAX_WAYS-1:0] inuse, vuse;
  logic                hit, have_inv;
  logic [WAY_W-1:0]    hit_way, inv_way, vic_way, sel_way;
  logic [RW-1:0]       vic_rank, rk;
  logic [4:0]          vcnt, old_rank;

  logic                         out_vld_q, hit_q, ev_q;
  logic [sacl_pkg::WAYOUT_W-1:0] way_q;
  logic [sacl_pkg::CNT_W-1:0]    acc_q, miss_q;

  // tag compare and replacement choice over the ways in use
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    have_inv = 1'b0;
    inv_way  = '0;
    vcnt     = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      inuse[w] = (w <= int'(nwm1_q));
      vuse[w]  = inuse[w] & vld_rd_q[w];
      if (vuse[w] && tag_rd_q[w*TAG_W +: TAG_W] == tag_q) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (inuse[w] && !vld_rd_q[w]) begin
        have_inv = 1'b1;
        inv_way  = WAY_W'(w);
      end
      vcnt = vcnt + 5'(vuse[w]);
    end
    vic_way  = '0;
    vic_rank = rank_rd_q[RW-1:0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (inuse[w] && rank_rd_q[w*RW +: RW] > vic_rank) begin
        vic_rank = rank_rd_q[w*RW +: RW];
        vic_way  = WAY_W'(w);
      end
    end
    if (hit) begin
      sel_way  = hit_way;
      old_rank = 5'(rank_rd_q[int'(hit_way)*RW +: RW]);
    end else if (have_inv) begin
      sel_way  = inv_way;
      old_rank = vcnt;
    end else begin
      sel_way  = vic_way;
      old_rank = 5'(vic_rank);
    end
    rank_wr = rank_rd_q;
    tag_wr  = tag_rd_q;
    vld_wr  = vld_rd_q;
    for (int w = 0; w < MAX_WAYS; w++) begin
      rk = rank_rd_q[w*RW +: RW];
      if (w == int'(sel_way)) begin
        rank_wr[w*RW +: RW] = '0;
        tag_wr[w*TAG_W +: TAG_W] = tag_q;
        vld_wr[w] = 1'b1;
      end else if (vuse[w] && 5'(rk) < old_rank && rk != RANK_MAX) begin
        rank_wr[w*RW +: RW] = rk + 1'b1;
      end
    end
  end

  assign pop_ready_o = (state_q == ST_IDLE);
  assign rd_en       = pop_ready_o & pop_valid_i;
  assign commit      = (state_q == ST_EVAL) & (!out_vld_q | out_if.ready);
  assign tag_we      = commit & !hit;
  assign meta_we     = commit | (state_q == ST_CLEAR);
  assign wr_idx      = (state_q == ST_CLEAR) ? clr_q : set_q;
  assign ready_o     = (state_q != ST_CLEAR);

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[wr_idx] <= tag_wr;
    end
    if (meta_we) begin
      vld_mem[wr_idx]  <= (state_q == ST_CLEAR) ? '0 : vld_wr;
      rank_mem[wr_idx] <= (state_q == ST_CLEAR) ? '0 : rank_wr;
    end
    if (rd_en) begin
      tag_rd_q  <= tag_mem[pop_data_i[IDX_W-1:0]];
      vld_rd_q  <= vld_mem[pop_data_i[IDX_W-1:0]];
      rank_rd_q <= rank_mem[pop_data_i[IDX_W-1:0]];
      set_q     <= pop_data_i[IDX_W-1:0];
      tag_q     <= pop_data_i[IDX_W +: TAG_W];
      nwm1_q    <= pop_data_i[IDX_W+TAG_W +: sacl_pkg::NWAYS_W];
    end
    if (commit) begin
      hit_q <= hit;
      ev_q  <= !hit & !have_inv;
      way_q <= sacl_pkg::WAYOUT_W'(sel_way);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == LAST_SET) state_d = ST_IDLE;
      ST_IDLE:  if (rd_en) state_d = ST_EVAL;
      ST_EVAL:  if (commit) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
      acc_q     <= '0;
      miss_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (commit) begin
        out_vld_q <= 1'b1;
        if (acc_q != '1) begin
          acc_q <= acc_q + 1'b1;
        end
        if (!hit && miss_q != '1) begin
          miss_q <= miss_q + 1'b1;
        end
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_if.valid        = out_vld_q;
  assign out_if.hit          = hit_q;
  assign out_if.way_used     = way_q;
  assign out_if.evicted      = ev_q;
  assign out_if.access_count = acc_q;
  assign out_if.miss_count   = miss_q;

endmodule
`default_nettype wire

// ----- hdl/set_assoc_cache_lru_lookup_top.sv -----
// top level of the set-associative cache lookup with true lru replacement
// depends on sacl_pkg, sacl_if, sacl_front, sacl_fifo, sacl_back
//
//   channel | dir | payload                                           | accepted when
//   in_if   | in  | address                                           | valid & ready
//   out_if  | out | hit, way_used, evicted, access_count, miss_count  | valid & ready
//   cfg_if  | in  | index, data                                       | valid & ready
//
// after reset the set store is cleared one set per cycle, all MAX_SETS sets,
// during which no address is taken; config writes are taken at any time
// the back end reads the set row in ST_IDLE, then compares, updates lru and writes
// back in ST_EVAL once the output register is free or being read, then takes the
// next address; a two-entry queue and the output register let each side stall on its own
`default_nettype none
module set_assoc_cache_lru_lookup_top #(
  parameter int MAX_SETS  = sacl_pkg::DEF_MAX_SETS,
  parameter int MAX_WAYS  = sacl_pkg::DEF_MAX_WAYS,
  parameter int ADDR_BITS = sacl_pkg::DEF_ADDR_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sacl_in_if.sink    in_if,
  sacl_out_if.source out_if,
  sacl_cfg_if.sink   cfg_if
);

  localparam int IDX_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int TAG_W  = (ADDR_BITS < sacl_pkg::ADDR_W) ? ADDR_BITS : sacl_pkg::ADDR_W;
  localparam int ITEM_W = IDX_W + TAG_W + sacl_pkg::NWAYS_W;

  sacl_pkg::cfg_t cfg_q;
  logic              push_valid, push_ready, pop_valid, pop_ready, en;
  logic [ITEM_W-1:0] push_data, pop_data;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_bits <= sacl_pkg::RST_OFFSET_BITS;
      cfg_q.set_bits    <= sacl_pkg::RST_SET_BITS;
      cfg_q.ways_log    <= sacl_pkg::RST_WAYS_LOG;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        sacl_pkg::CFG_OFFSET_BITS: cfg_q.offset_bits <= cfg_if.data;
        sacl_pkg::CFG_SET_BITS:    cfg_q.set_bits    <= cfg_if.data;
        sacl_pkg::CFG_WAYS_LOG:    cfg_q.ways_log    <= cfg_if.data[1:0];
        default: ;
      endcase
    end
  end

  sacl_front #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS),
    .ADDR_BITS(ADDR_BITS),
    .IDX_W    (IDX_W),
    .TAG_W    (TAG_W)
  ) u_front (
    .cfg_i       (cfg_q),
    .en_i        (en),
    .in_if       (in_if),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  sacl_fifo #(
    .WIDTH(ITEM_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  sacl_back #(
    .MAX_SETS(MAX_SETS),
    .MAX_WAYS(MAX_WAYS),
    .IDX_W   (IDX_W),
    .TAG_W   (TAG_W),
    .WAY_W   (WAY_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .ready_o    (en),
    .out_if     (out_if)
  );

endmodule
`default_nettype wire

// ----- bench/sacl_tb_if.sv -----
// result record used by the testbench predictor and checker
// no dependencies
`timescale 1ns / 100ps
package sacl_tb_types;
  typedef struct packed {
    logic        hit;
    logic [2:0]  way_used;
    logic        evicted;
    logic [31:0] access_count;
    logic [31:0] miss_count;
  } lookup_res_t;
endpackage

// ----- bench/set_assoc_cache_lru_lookup_top_test.sv -----
// testbench for set_assoc_cache_lru_lookup_top: directed and random address
// traces checked against a behavioral lru cache predictor
// depends on sacl_pkg, sacl_if, sacl_tb_types and the rtl
`timescale 1ns / 100ps
module set_assoc_cache_lru_lookup_top_test;

  localparam int N_SETS = 1024;
  localparam int N_WAYS = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sacl_in_if  in_if();
  sacl_out_if out_if();
  sacl_cfg_if cfg_if();

  set_assoc_cache_lru_lookup_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [3:0]  cur_offset_bits, cur_set_bits;
  logic [1:0]  cur_ways_log;
  logic [31:0] line_tag  [N_SETS*N_WAYS];
  bit          line_valid[N_SETS*N_WAYS];
  logic [2:0]  line_rank [N_SETS*N_WAYS];
  logic [31:0] accesses, misses;

  sacl_tb_types::lookup_res_t pending_results[$];
  int  error_count = 0;
  int  accepted_items = 0, checked_results = 0, hit_total = 0, evict_total = 0;
  int  idle_pct = 23;
  int  idle_cycles = 0;
  bit  timed_out = 0;

  function automatic void promote_way(int base, int ways, int w, int old_rank);
    for (int v = 0; v < ways; v++) begin
      if (v != w && line_valid[base+v] && int'(line_rank[base+v]) < old_rank &&
          line_rank[base+v] < 3'd7)
        line_rank[base+v] = line_rank[base+v] + 3'd1;
    end
    line_rank[base+w] = 3'd0;
  endfunction

  function automatic sacl_tb_types::lookup_res_t lookup_address(logic [31:0] addr);
    sacl_tb_types::lookup_res_t r;
    int ob, sb, ways, set_no, base, fill, hit_way, valid_cnt, best;
    bit hit, have_inv;
    logic [31:0] tag;
    ob = (cur_offset_bits > 4'd8) ? 8 : int'(cur_offset_bits);
    sb = int'(cur_set_bits);
    while (sb > 0 && (1 << sb) > N_SETS) sb--;
    ways = 1 << cur_ways_log;
    set_no = int'((addr >> ob) & ((32'd1 << sb) - 32'd1));
    tag = (ob + sb >= 32) ? 32'd0 : addr >> (ob + sb);
    base = set_no * N_WAYS;
    hit = 0; have_inv = 0; fill = 0; hit_way = 0; valid_cnt = 0;
    if (accesses != 32'hFFFF_FFFF) accesses++;
    for (int w = 0; w < ways; w++) begin
      if (line_valid[base+w]) begin
        valid_cnt++;
        if (!hit && line_tag[base+w] == tag) begin
          hit = 1; hit_way = w;
        end
      end else if (!have_inv) begin
        have_inv = 1; fill = w;
      end
    end
    r.evicted = 1'b0;
    if (hit) begin
      promote_way(base, ways, hit_way, int'(line_rank[base+hit_way]));
      fill = hit_way;
    end else begin
      if (misses != 32'hFFFF_FFFF) misses++;
      if (have_inv) promote_way(base, ways, fill, valid_cnt);
      else begin
        fill = 0; best = int'(line_rank[base]);
        for (int w = 1; w < ways; w++)
          if (int'(line_rank[base+w]) > best) begin
            best = int'(line_rank[base+w]); fill = w;
          end
        r.evicted = 1'b1;
        promote_way(base, ways, fill, best);
      end
      line_tag[base+fill] = tag;
      line_valid[base+fill] = 1;
    end
    r.hit = hit;
    r.way_used = fill[2:0];
    r.access_count = accesses;
    r.miss_count = misses;
    return r;
  endfunction

  task automatic send_address(logic [31:0] addr);
    sacl_tb_types::lookup_res_t exp_r;
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    in_if.valid = 1'b1;
    in_if.address = addr;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    exp_r = lookup_address(addr);
    pending_results = {pending_results, exp_r};
    accepted_items++;
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(sacl_pkg::cfg_idx_e idx, logic [3:0] val);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      sacl_pkg::CFG_OFFSET_BITS: cur_offset_bits = val;
      sacl_pkg::CFG_SET_BITS:    cur_set_bits = val;
      sacl_pkg::CFG_WAYS_LOG:    cur_ways_log = val[1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_geometry(logic [3:0] ob, logic [3:0] sb, logic [1:0] wl);
    drain_results();
    write_reg(sacl_pkg::CFG_OFFSET_BITS, ob);
    write_reg(sacl_pkg::CFG_SET_BITS, sb);
    write_reg(sacl_pkg::CFG_WAYS_LOG, {2'b00, wl});
  endtask

  // address into a chosen set with one of a few tags, so sets fill and evict
  function automatic logic [31:0] local_address(int set_no, int tag_no);
    int ob, sb;
    ob = (cur_offset_bits > 4'd8) ? 8 : int'(cur_offset_bits);
    sb = (cur_set_bits > 4'd10) ? 10 : int'(cur_set_bits);
    return (32'(tag_no) << (ob + sb)) | (32'(set_no) << ob) |
           ($urandom & ((32'd1 << ob) - 32'd1));
  endfunction

  task automatic test_directed_extremes();
    send_address(32'h0000_0000);
    send_address(32'hFFFF_FFFF);
    send_address(32'h0000_0000);
    send_address(32'hFFFF_FFFF);
    send_address(32'hAAAA_AAAA);
    send_address(32'h5555_5555);
  endtask

  task automatic test_fill_and_evict();
    set_geometry(4'd4, 4'd2, 2'd3);
    for (int t = 0; t < 9; t++) send_address(local_address(1, t));
    send_address(local_address(1, 3));
    send_address(local_address(1, 0));
    send_address(local_address(1, 1));
    // large registers, out of range offset, single set
    set_geometry(4'd15, 4'd0, 2'd1);
    send_address(32'h0000_0100);
    send_address(32'h0000_0200);
    send_address(32'h0000_0300);
    set_geometry(4'd0, 4'd15, 2'd2);
    send_address(32'hFFFF_FFFF);
    send_address(32'h0000_0000);
  endtask

  task automatic test_random_traces(int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0)
        set_geometry(4'($urandom_range(15)), 4'($urandom_range(15)),
                     2'($urandom_range(3)));
      if (i == 250) begin
        idle_pct = 0;
        drain_results();
      end
      if (i == 350) idle_pct = 23;
      if ($urandom_range(9) < 8)
        send_address(local_address(int'($urandom_range(3)), int'($urandom_range(11))));
      else
        send_address($urandom);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    sacl_tb_types::lookup_res_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        checked_results++;
        if (exp_r.hit) hit_total++;
        if (exp_r.evicted) evict_total++;
        if (out_if.hit !== exp_r.hit) begin
          $error("hit: expected %0d actual %0d", exp_r.hit, out_if.hit); error_count++;
        end
        if (out_if.way_used !== exp_r.way_used) begin
          $error("way_used: expected %0d actual %0d", exp_r.way_used, out_if.way_used);
          error_count++;
        end
        if (out_if.evicted !== exp_r.evicted) begin
          $error("evicted: expected %0d actual %0d", exp_r.evicted, out_if.evicted);
          error_count++;
        end
        if (out_if.access_count !== exp_r.access_count) begin
          $error("access_count: expected %0d actual %0d", exp_r.access_count,
                 out_if.access_count);
          error_count++;
        end
        if (out_if.miss_count !== exp_r.miss_count) begin
          $error("miss_count: expected %0d actual %0d", exp_r.miss_count,
                 out_if.miss_count);
          error_count++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_if.ready <= (idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= 23);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1;
    end
  end

  always @(posedge timed_out) begin
    $display("watchdog expired with %0d results outstanding", pending_results.size());
    $display("** set_assoc_cache_lru_lookup_top: FAILED **");
    $finish;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.address = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = sacl_pkg::CFG_OFFSET_BITS;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    cur_offset_bits = sacl_pkg::RST_OFFSET_BITS;
    cur_set_bits = sacl_pkg::RST_SET_BITS;
    cur_ways_log = sacl_pkg::RST_WAYS_LOG;
    accesses = '0;
    misses = '0;
    for (int i = 0; i < N_SETS*N_WAYS; i++) begin
      line_valid[i] = 0;
      line_rank[i] = '0;
      line_tag[i] = '0;
    end
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_extremes();
    test_fill_and_evict();
    test_random_traces(480);
    drain_results();
    $display("covered %0d addresses over many cache geometries: %0d hits, %0d evictions",
             accepted_items, hit_total, evict_total);
    $display("%0d results compared field by field", checked_results);
    if (error_count == 0 && pending_results.size() == 0)
      $display("** set_assoc_cache_lru_lookup_top: PASSED **");
    else
      $display("** set_assoc_cache_lru_lookup_top: FAILED **");
    $finish;
  end
endmodule
